// ----- hw/rtl/gregorian_date_arithmetic_macros.svh -----
// ----------------------------------------------------------------------------
// gregorian date arithmetic assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ARITHMETIC_MACROS_SVH
`define GREGORIAN_DATE_ARITHMETIC_MACROS_SVH

// same-cycle implication
`define GDA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gda assertion failed");

// next-cycle implication
`define GDA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gda assertion failed");

`endif

// ----- hw/rtl/gda_pkg.sv -----
// ----------------------------------------------------------------------------
// gda_pkg
// types, constants and calendar tables of the gregorian date arithmetic unit
// ----------------------------------------------------------------------------
package gda_pkg;

    localparam int unsigned MAX_YEAR_DEF   = 9999;
    localparam int unsigned DELTA_BITS_DEF = 16;

    // day numbers up to year 65535 fit in 25 bits
    localparam int unsigned NUM_W  = 25;
    localparam int unsigned DIFF_W = 22;

    localparam logic [DIFF_W-1:0] DIFF_MAX = {DIFF_W{1'b1}};

    localparam int unsigned D400 = 146097;
    localparam int unsigned D100 = 36524;
    localparam int unsigned D4   = 1461;
    localparam int unsigned D1   = 365;

    // reciprocals, exact over the value ranges seen at each step
    localparam logic [25:0] K400  = 26'(((64'd1 << 43) + 64'd146096) / 64'd146097);
    localparam logic [17:0] K100  = 18'(((64'd1 << 33) + 64'd36523) / 64'd36524);
    localparam logic [15:0] K4    = 16'(((64'd1 << 26) + 64'd1460) / 64'd1461);
    localparam logic [11:0] K1    = 12'(((64'd1 << 20) + 64'd364) / 64'd365);
    localparam logic [17:0] K100Y = 18'(((64'd1 << 24) + 64'd99) / 64'd100);

    typedef enum logic [1:0] {
        FUNC_ADD  = 2'd0,
        FUNC_SUB  = 2'd1,
        FUNC_DIFF = 2'd2,
        FUNC_RSVD = 2'd3
    } t_func;

    typedef struct packed {
        logic              dt;
        logic              err;
        logic [DIFF_W-1:0] diff;
        logic [NUM_W-1:0]  r;
        logic [7:0]        q400;
        logic [1:0]        q100;
        logic [4:0]        q4;
        logic [1:0]        q1;
        logic [15:0]       year;
        logic              leap;
        logic [3:0]        month;
        logic [4:0]        day;
    } t_bk;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] l;
        case (m)
            4'd4, 4'd6, 4'd9, 4'd11: l = 5'd30;
            4'd2:                    l = leap ? 5'd29 : 5'd28;
            default:                 l = 5'd31;
        endcase
        return l;
    endfunction

    // days of the year before the first of month m
    function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
        logic [8:0] c;
        logic [8:0] lp;
        lp = {8'd0, leap};
        case (m)
            4'd1:    c = 9'd0;
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59 + lp;
            4'd4:    c = 9'd90 + lp;
            4'd5:    c = 9'd120 + lp;
            4'd6:    c = 9'd151 + lp;
            4'd7:    c = 9'd181 + lp;
            4'd8:    c = 9'd212 + lp;
            4'd9:    c = 9'd243 + lp;
            4'd10:   c = 9'd273 + lp;
            4'd11:   c = 9'd304 + lp;
            4'd12:   c = 9'd334 + lp;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/gregorian_date_arithmetic.sv -----
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic
// add or subtract days from a date, or the absolute day count between dates
// ----------------------------------------------------------------------------
// Fourteen-stage pipeline: a request enters every cycle while the output
// is not held. Dates become linear day numbers, the sum, difference or
// distance is taken, and the day number is split back into 400, 100, 4
// and 1 year periods through reciprocal multipliers, each in its own
// stage. The pipeline holds as a whole while a finished result waits at
// the output, so o_ready is low exactly while the output is held.
`include "gregorian_date_arithmetic_macros.svh"

module gregorian_date_arithmetic #(
    parameter int unsigned MAX_YEAR   = gda_pkg::MAX_YEAR_DEF,
    parameter int unsigned DELTA_BITS = gda_pkg::DELTA_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [4:0]  i_day_a,
    input  logic [3:0]  i_month_a,
    input  logic [13:0] i_year_a,
    input  logic [15:0] i_delta,
    input  logic [4:0]  i_day_b,
    input  logic [3:0]  i_month_b,
    input  logic [13:0] i_year_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_res_day,
    output logic [3:0]  o_res_month,
    output logic [13:0] o_res_year,
    output logic [21:0] o_day_diff,
    output logic        o_err
);

    localparam int unsigned NW     = gda_pkg::NUM_W;
    localparam int unsigned STAGES = 14;
    localparam int unsigned DB     = (DELTA_BITS < 16) ? DELTA_BITS : 16;
    localparam logic [15:0] DELTA_MASK = 16'((32'd1 << DB) - 32'd1);
    localparam logic [NW-1:0] LAST = NW'(MAX_YEAR * 365 + MAX_YEAR / 4
                                        - MAX_YEAR / 100 + MAX_YEAR / 400 - 1);

    logic               en;
    logic [STAGES-1:0]  r_vld;

    // front end, one slot per date
    logic [4:0]    in_d [2];
    logic [3:0]    in_m [2];
    logic [13:0]   in_y [2];

    logic [15:0]   n1_p [2], r1_p [2];
    logic [33:0]   prod1 [2];
    logic [9:0]    n1_q [2], r1_q [2];
    logic          n1_yok [2], r1_yok [2];
    logic [4:0]    r1_d [2];
    logic [3:0]    r1_m [2];
    logic [1:0]    r1_func;
    logic [15:0]   r1_delta;

    logic [15:0]   rem [2];
    logic          lp [2];
    logic          n2_ok [2], r2_ok [2];
    logic [NW-1:0] n2_base [2], r2_base [2];
    logic [8:0]    n2_doy [2], r2_doy [2];
    logic [1:0]    r2_func;
    logic [15:0]   r2_delta;

    logic [NW-1:0] r3_n [2];
    logic          r3_ok [2];
    logic [1:0]    r3_func;
    logic [15:0]   r3_delta;

    logic              n4_dt, r4_dt;
    logic              n4_err, r4_err;
    logic [21:0]       n4_diff, r4_diff;
    logic [NW-1:0]     n4_n, r4_n;
    logic [NW:0]       sum4;
    logic [NW-1:0]     abs4;

    gda_pkg::t_bk  n_bk [10];
    gda_pkg::t_bk  r_bk [10];
    logic [50:0]   m400;
    logic [35:0]   m100;
    logic [31:0]   m4;
    logic [22:0]   m1;
    logic [3:0]    mcnt;

    assign en      = !r_vld[STAGES-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[STAGES-1];

    assign in_d[0] = i_day_a;
    assign in_d[1] = i_day_b;
    assign in_m[0] = i_month_a;
    assign in_m[1] = i_month_b;
    assign in_y[0] = i_year_a;
    assign in_y[1] = i_year_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    // stage 1: year minus one and its hundreds
    always_comb begin
        for (int j = 0; j < 2; j++) begin
            n1_p[j]   = {2'b00, in_y[j]} - 16'd1;
            prod1[j]  = 34'(n1_p[j]) * 34'(gda_pkg::K100Y);
            n1_q[j]   = prod1[j][33:24];
            n1_yok[j] = (in_y[j] != 14'd0) && ({2'b00, in_y[j]} <= 16'(MAX_YEAR));
        end
    end

    // stage 2: leap year, validity, day number parts
    always_comb begin
        for (int j = 0; j < 2; j++) begin
            rem[j] = r1_p[j] - 16'(r1_q[j]) * 16'd100;
            lp[j]  = (r1_p[j][1:0] == 2'b11) && ((rem[j] != 16'd99) || (r1_q[j][1:0] == 2'b11));
            n2_ok[j] = r1_yok[j] && (r1_m[j] >= 4'd1) && (r1_m[j] <= 4'd12)
                       && (r1_d[j] >= 5'd1) && (r1_d[j] <= gda_pkg::month_len(r1_m[j], lp[j]));
            n2_base[j] = NW'(r1_p[j]) * NW'(365) + NW'(r1_p[j][15:2])
                         - NW'(r1_q[j]) + NW'(r1_q[j][9:2]);
            n2_doy[j]  = gda_pkg::cum_days(r1_m[j], lp[j]) + 9'(r1_d[j]) - 9'd1;
        end
    end

    // stage 4: the operation itself
    always_comb begin
        sum4    = {1'b0, r3_n[0]} + (NW + 1)'(r3_delta);
        abs4    = (r3_n[0] >= r3_n[1]) ? (r3_n[0] - r3_n[1]) : (r3_n[1] - r3_n[0]);
        n4_dt   = 1'b1;
        n4_err  = !r3_ok[0];
        n4_diff = '0;
        n4_n    = r3_n[0];
        case (r3_func)
            gda_pkg::FUNC_ADD: begin
                if (sum4 > {1'b0, LAST}) begin
                    n4_err = 1'b1;
                end
                n4_n = sum4[NW-1:0];
            end
            gda_pkg::FUNC_SUB: begin
                if (NW'(r3_delta) > r3_n[0]) begin
                    n4_err = 1'b1;
                end
                n4_n = r3_n[0] - NW'(r3_delta);
            end
            gda_pkg::FUNC_DIFF: begin
                n4_dt  = 1'b0;
                n4_err = !r3_ok[0] || !r3_ok[1];
                if (abs4 > NW'(gda_pkg::DIFF_MAX)) begin
                    n4_diff = gda_pkg::DIFF_MAX;
                end else begin
                    n4_diff = abs4[21:0];
                end
                if (n4_err) begin
                    n4_diff = '0;
                end
            end
            default: begin
                n4_dt  = 1'b0;
                n4_err = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 2; j++) begin
                r1_p[j]    <= n1_p[j];
                r1_q[j]    <= n1_q[j];
                r1_yok[j]  <= n1_yok[j];
                r1_d[j]    <= in_d[j];
                r1_m[j]    <= in_m[j];
                r2_ok[j]   <= n2_ok[j];
                r2_base[j] <= n2_base[j];
                r2_doy[j]  <= n2_doy[j];
                r3_n[j]    <= r2_base[j] + NW'(r2_doy[j]);
                r3_ok[j]   <= r2_ok[j];
            end
            r1_func  <= i_func;
            r1_delta <= i_delta & DELTA_MASK;
            r2_func  <= r1_func;
            r2_delta <= r1_delta;
            r3_func  <= r2_func;
            r3_delta <= r2_delta;
            r4_dt    <= n4_dt;
            r4_err   <= n4_err;
            r4_diff  <= n4_diff;
            r4_n     <= n4_n;
        end
    end

    // stages 5 to 14: day number back to a date
    always_comb begin
        m400 = 51'(r4_n) * 51'(gda_pkg::K400);
        m100 = 36'(r_bk[1].r[17:0]) * 36'(gda_pkg::K100);
        m4   = 32'(r_bk[3].r[15:0]) * 32'(gda_pkg::K4);
        m1   = 23'(r_bk[5].r[10:0]) * 23'(gda_pkg::K1);
        mcnt = 4'd1;
        for (int k = 2; k <= 12; k++) begin
            if (r_bk[7].r[8:0] >= gda_pkg::cum_days(4'(k), r_bk[7].leap)) begin
                mcnt = mcnt + 4'd1;
            end
        end

        n_bk[0]      = '0;
        n_bk[0].dt   = r4_dt;
        n_bk[0].err  = r4_err;
        n_bk[0].diff = r4_diff;
        n_bk[0].r    = r4_n;
        n_bk[0].q400 = m400[50:43];

        n_bk[1]   = r_bk[0];
        n_bk[1].r = r_bk[0].r - NW'(r_bk[0].q400) * NW'(gda_pkg::D400);

        n_bk[2]      = r_bk[1];
        n_bk[2].q100 = (m100[35:33] > 3'd3) ? 2'd3 : m100[34:33];

        n_bk[3]   = r_bk[2];
        n_bk[3].r = r_bk[2].r - NW'(r_bk[2].q100) * NW'(gda_pkg::D100);

        n_bk[4]    = r_bk[3];
        n_bk[4].q4 = m4[30:26];

        n_bk[5]   = r_bk[4];
        n_bk[5].r = r_bk[4].r - NW'(r_bk[4].q4) * NW'(gda_pkg::D4);

        n_bk[6]    = r_bk[5];
        n_bk[6].q1 = (m1[22:20] > 3'd3) ? 2'd3 : m1[21:20];

        n_bk[7]      = r_bk[6];
        n_bk[7].r    = r_bk[6].r - NW'(r_bk[6].q1) * NW'(gda_pkg::D1);
        n_bk[7].year = 16'(r_bk[6].q400) * 16'd400 + 16'(r_bk[6].q100) * 16'd100
                       + 16'(r_bk[6].q4) * 16'd4 + 16'(r_bk[6].q1) + 16'd1;
        n_bk[7].leap = (r_bk[6].q1 == 2'd3)
                       && ((r_bk[6].q4 != 5'd24) || (r_bk[6].q100 == 2'd3));

        n_bk[8]       = r_bk[7];
        n_bk[8].month = mcnt;

        n_bk[9]     = r_bk[8];
        n_bk[9].day = 5'(r_bk[8].r[8:0] - gda_pkg::cum_days(r_bk[8].month, r_bk[8].leap)
                         + 9'd1);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 10; k++) begin
                r_bk[k] <= n_bk[k];
            end
        end
    end

    assign o_res_day   = (r_bk[9].dt && !r_bk[9].err) ? r_bk[9].day : 5'd0;
    assign o_res_month = (r_bk[9].dt && !r_bk[9].err) ? r_bk[9].month : 4'd0;
    assign o_res_year  = (r_bk[9].dt && !r_bk[9].err) ? r_bk[9].year[13:0] : 14'd0;
    assign o_day_diff  = r_bk[9].diff;
    assign o_err       = r_bk[9].err;

    `GDA_ASSERT_IMP(a_err_zero, o_valid && o_err, (o_res_day == 5'd0) && (o_res_month == 4'd0) && (o_res_year == 14'd0) && (o_day_diff == 22'd0))
    `GDA_ASSERT_IMP(a_date_ok, o_valid && !o_err && (o_res_month != 4'd0), (o_res_day != 5'd0) && (o_res_month <= 4'd12) && (o_day_diff == 22'd0))
    `GDA_ASSERT_NXT(a_hold, !en, $stable(r_vld))

endmodule

// ----- dv/date_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// date_checker
// watches the request and result channels of the date arithmetic unit,
// computes each expected date or day distance and compares field by field
// ----------------------------------------------------------------------------
module date_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_req_ready,
    input  logic [1:0]  i_func,
    input  logic [4:0]  i_day_a,
    input  logic [3:0]  i_month_a,
    input  logic [13:0] i_year_a,
    input  logic [15:0] i_delta,
    input  logic [4:0]  i_day_b,
    input  logic [3:0]  i_month_b,
    input  logic [13:0] i_year_b,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [4:0]  i_res_day,
    input  logic [3:0]  i_res_month,
    input  logic [13:0] i_res_year,
    input  logic [21:0] i_day_diff,
    input  logic        i_err,
    output int          o_fail_count,
    output int          o_pending
);
    import gda_pkg::*;

    localparam int unsigned LAST_YEAR = MAX_YEAR_DEF;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [21:0] diff;
        logic        err;
    } t_date_res;

    t_date_res expected_dates[$];

    function automatic bit is_leap(longint y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic longint days_in_month(longint m, longint y);
        if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
        if (m == 2) return is_leap(y) ? 29 : 28;
        return 31;
    endfunction

    function automatic bit date_ok(longint d, longint m, longint y);
        if (y < 1 || y > LAST_YEAR) return 0;
        if (m < 1 || m > 12) return 0;
        return d >= 1 && d <= days_in_month(m, y);
    endfunction

    function automatic longint day_number(longint d, longint m, longint y);
        longint p;
        longint n;
        p = y - 1;
        n = p * 365 + p / 4 - p / 100 + p / 400;
        for (longint i = 1; i < m; i++) n += days_in_month(i, y);
        return n + d - 1;
    endfunction

    function automatic t_date_res calendar_date(longint n);
        t_date_res res;
        longint q400, q100, q4, q1, r, y, mon;
        q400 = n / 146097;
        r = n % 146097;
        q100 = r / 36524;
        if (q100 > 3) q100 = 3;
        r -= q100 * 36524;
        q4 = r / 1461;
        r -= q4 * 1461;
        q1 = r / 365;
        if (q1 > 3) q1 = 3;
        r -= q1 * 365;
        y = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
        mon = 1;
        while (mon < 12 && r >= days_in_month(mon, y)) begin
            r -= days_in_month(mon, y);
            mon++;
        end
        res = '0;
        res.day = 5'(r + 1);
        res.month = 4'(mon);
        res.year = 14'(y);
        return res;
    endfunction

    function automatic t_date_res date_result(logic [1:0] f, longint da, longint ma,
                                              longint ya, longint dl, longint db,
                                              longint mb, longint yb);
        t_date_res res;
        longint na, nb, span;
        res = '0;
        if (f == FUNC_ADD || f == FUNC_SUB) begin
            if (!date_ok(da, ma, ya)) begin
                res.err = 1'b1;
            end else begin
                na = day_number(da, ma, ya);
                if (f == FUNC_ADD) begin
                    if (na + dl > day_number(31, 12, LAST_YEAR)) res.err = 1'b1;
                    else res = calendar_date(na + dl);
                end else begin
                    if (dl > na) res.err = 1'b1;
                    else res = calendar_date(na - dl);
                end
            end
        end else if (f == FUNC_DIFF) begin
            if (!date_ok(da, ma, ya) || !date_ok(db, mb, yb)) begin
                res.err = 1'b1;
            end else begin
                na = day_number(da, ma, ya);
                nb = day_number(db, mb, yb);
                span = na >= nb ? na - nb : nb - na;
                if (span > longint'(DIFF_MAX)) span = longint'(DIFF_MAX);
                res.diff = 22'(span);
            end
        end else begin
            res.err = 1'b1;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_date_res want;
        if (!i_rst_n) begin
            expected_dates.delete();
            o_fail_count <= 0;
        end else begin
            if (i_valid && i_req_ready)
                expected_dates.push_back(date_result(i_func, i_day_a, i_month_a, i_year_a,
                                                     i_delta, i_day_b, i_month_b, i_year_b));
            if (i_res_valid && i_res_ready) begin
                if (expected_dates.size() == 0) begin
                    $error("result with no request outstanding");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_dates.pop_front();
                    if (want.day != i_res_day || want.month != i_res_month ||
                        want.year != i_res_year || want.diff != i_day_diff ||
                        want.err != i_err)
                        o_fail_count <= o_fail_count + 1;
                    if (want.day != i_res_day)
                        $error("res_day expected %0d actual %0d", want.day, i_res_day);
                    if (want.month != i_res_month)
                        $error("res_month expected %0d actual %0d", want.month, i_res_month);
                    if (want.year != i_res_year)
                        $error("res_year expected %0d actual %0d", want.year, i_res_year);
                    if (want.diff != i_day_diff)
                        $error("day_diff expected %0d actual %0d", want.diff, i_day_diff);
                    if (want.err != i_err)
                        $error("err expected %0d actual %0d", want.err, i_err);
                end
            end
        end
        o_pending <= expected_dates.size();
    end
endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// directed edge dates then random date requests under varying idle and stall
// patterns; a checker beside the unit predicts and compares every result
// ----------------------------------------------------------------------------
module testbench;
    import gda_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [1:0]  func = '0;
    logic [4:0]  day_a = 5'd1;
    logic [3:0]  month_a = 4'd1;
    logic [13:0] year_a = 14'd1;
    logic [15:0] delta = '0;
    logic [4:0]  day_b = 5'd1;
    logic [3:0]  month_b = 4'd1;
    logic [13:0] year_b = 14'd1;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [4:0]  res_day;
    logic [3:0]  res_month;
    logic [13:0] res_year;
    logic [21:0] day_diff;
    logic        err;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          stall_pct = 0;

    always #10 clk = ~clk;

    gregorian_date_arithmetic DUT (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(req_valid), .o_ready(req_ready),
        .i_func(func), .i_day_a(day_a), .i_month_a(month_a), .i_year_a(year_a),
        .i_delta(delta), .i_day_b(day_b), .i_month_b(month_b), .i_year_b(year_b),
        .o_valid(res_valid), .i_ready(res_ready), .o_res_day(res_day),
        .o_res_month(res_month), .o_res_year(res_year), .o_day_diff(day_diff),
        .o_err(err)
    );

    date_checker u_date_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(req_valid), .i_req_ready(req_ready),
        .i_func(func), .i_day_a(day_a), .i_month_a(month_a), .i_year_a(year_a),
        .i_delta(delta), .i_day_b(day_b), .i_month_b(month_b), .i_year_b(year_b),
        .i_res_valid(res_valid), .i_res_ready(res_ready), .i_res_day(res_day),
        .i_res_month(res_month), .i_res_year(res_year), .i_day_diff(day_diff),
        .i_err(err), .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(negedge clk)
        res_ready <= ($urandom_range(99) >= stall_pct);

    task automatic send_request(logic [1:0] f, logic [4:0] da, logic [3:0] ma,
                                logic [13:0] ya, logic [15:0] dl, logic [4:0] db,
                                logic [3:0] mb, logic [13:0] yb);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        func <= f;
        day_a <= da;
        month_a <= ma;
        year_a <= ya;
        delta <= dl;
        day_b <= db;
        month_b <= mb;
        year_b <= yb;
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
    endtask

    task automatic random_request();
        logic [1:0]  f;
        logic [13:0] ya;
        logic [13:0] yb;
        logic [15:0] dl;
        int          pick;
        f = FUNC_ADD + 2'($urandom_range(2));
        if ($urandom_range(99) < 3) f = FUNC_RSVD;
        pick = $urandom_range(9);
        ya = (pick < 5) ? 14'($urandom_range(9999, 1))
           : (pick < 7) ? 14'($urandom_range(9999, 9900))
           : (pick < 9) ? 14'($urandom_range(200, 1)) : 14'($urandom);
        yb = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(9999, 1));
        dl = ($urandom_range(3) == 0) ? 16'($urandom_range(400)) : 16'($urandom);
        if ($urandom_range(9) == 0)
            send_request(f, 5'($urandom), 4'($urandom), ya, dl,
                         5'($urandom), 4'($urandom), yb);
        else
            send_request(f, 5'($urandom_range(31, 1)), 4'($urandom_range(12, 1)), ya, dl,
                         5'($urandom_range(31, 1)), 4'($urandom_range(12, 1)), yb);
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_request(FUNC_ADD, 5'd1, 4'd1, 14'd1, 16'd0, 5'd1, 4'd1, 14'd1);
        send_request(FUNC_ADD, 5'd28, 4'd2, 14'd2000, 16'd1, 5'd1, 4'd1, 14'd1);
        send_request(FUNC_ADD, 5'd28, 4'd2, 14'd1900, 16'd1, 5'd1, 4'd1, 14'd1);
        send_request(FUNC_ADD, 5'd31, 4'd12, 14'd9999, 16'd1, 5'd1, 4'd1, 14'd1);
        send_request(FUNC_ADD, 5'd1, 4'd1, 14'd9900, 16'hFFFF, 5'd1, 4'd1, 14'd1);
        send_request(FUNC_ADD, 5'd31, 4'd12, 14'd9999, 16'd0, 5'd1, 4'd1, 14'd1);
        send_request(FUNC_SUB, 5'd1, 4'd1, 14'd1, 16'd1, 5'd1, 4'd1, 14'd1);
        send_request(FUNC_SUB, 5'd1, 4'd3, 14'd2024, 16'd1, 5'd1, 4'd1, 14'd1);
        send_request(FUNC_SUB, 5'd31, 4'd12, 14'd9999, 16'hFFFF, 5'd1, 4'd1, 14'd1);
        send_request(FUNC_SUB, 5'd1, 4'd1, 14'd100, 16'hFFFF, 5'd1, 4'd1, 14'd1);
        send_request(FUNC_ADD, 5'd29, 4'd2, 14'd2100, 16'd0, 5'd1, 4'd1, 14'd1);
        send_request(FUNC_ADD, 5'd0, 4'd1, 14'd5, 16'd3, 5'd1, 4'd1, 14'd1);
        send_request(FUNC_ADD, 5'd31, 4'd15, 14'd5, 16'd3, 5'd1, 4'd1, 14'd1);
        send_request(FUNC_ADD, 5'd31, 4'd4, 14'd5, 16'd3, 5'd1, 4'd1, 14'd1);
        send_request(FUNC_ADD, 5'd5, 4'd5, 14'd0, 16'd3, 5'd1, 4'd1, 14'd1);
        send_request(FUNC_SUB, 5'd5, 4'd5, 14'h3FFF, 16'd3, 5'd1, 4'd1, 14'd1);
        send_request(FUNC_DIFF, 5'd1, 4'd1, 14'd1, 16'd0, 5'd31, 4'd12, 14'd9999);
        send_request(FUNC_DIFF, 5'd31, 4'd12, 14'd9999, 16'd0, 5'd1, 4'd1, 14'd1);
        send_request(FUNC_DIFF, 5'd1, 4'd3, 14'd2000, 16'hFFFF, 5'd28, 4'd2, 14'd2000);
        send_request(FUNC_DIFF, 5'd1, 4'd3, 14'd2000, 16'd0, 5'd30, 4'd2, 14'd2000);
        send_request(FUNC_DIFF, 5'd31, 4'd15, 14'h3FFF, 16'd0, 5'd31, 4'd15, 14'h3FFF);
        send_request(FUNC_RSVD, 5'd1, 4'd1, 14'd2000, 16'd1, 5'd1, 4'd1, 14'd2000);
        req_valid <= 1'b0;
        // drain before random traffic
        while (pending != 0 || res_valid) @(negedge clk);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 55 : 7) : 0;
            stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 55 : 7) : 0;
            repeat (210) random_request();
        end
        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
